// ===== src/lnet_pkg.sv =====
// ----------------------------------------------------------------------------
// lnet_pkg
// Shared types, command codes and the microcode table of the two-layer
// linear network with argmax decision.
// ----------------------------------------------------------------------------
package lnet_pkg;

  // command codes
  localparam logic [2:0] CMD_W1    = 3'd0;
  localparam logic [2:0] CMD_W2    = 3'd1;
  localparam logic [2:0] CMD_INPUT = 3'd2;
  localparam logic [2:0] CMD_EVAL  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  // microcode step addresses
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_W1_READ   = 4'd2;
  localparam logic [3:0] S_P_MUL     = 4'd3;
  localparam logic [3:0] S_K_ISSUE   = 4'd4;
  localparam logic [3:0] S_J_ADV     = 4'd5;
  localparam logic [3:0] S_I_ADV     = 4'd6;
  localparam logic [3:0] S_SCAN_PREP = 4'd7;
  localparam logic [3:0] S_SCAN      = 4'd8;
  localparam logic [3:0] S_EMIT      = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NONE     = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NOT_EVAL = 3'd2;
  localparam logic [2:0] C_K_MORE   = 3'd3;
  localparam logic [2:0] C_J_MORE   = 3'd4;
  localparam logic [2:0] C_I_MORE   = 3'd5;

  typedef struct packed {
    logic [2:0] cond;
    logic [3:0] target;
    logic       clr_cnt;   // clear all loop counters and addresses
    logic       clr_k;
    logic       w1_rd;     // read first weight and input value
    logic       p_ld;      // form input times first weight
    logic       w2_iss;    // issue one output term into the pipeline
    logic       j_adv;
    logic       i_adv;
    logic       scan_clr;
    logic       scan_cmp;
    logic       emit;
  } ctrl_t;

  typedef struct packed {
    logic is_eval;
    logic i_last;
    logic j_last;
    logic k_last;
  } stat_t;

  function automatic ctrl_t ucode(logic [3:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      S_DISPATCH: begin
        c.clr_cnt = 1'b1;
        c.cond    = C_NOT_EVAL;
        c.target  = S_SCAN_PREP;
      end
      S_W1_READ: begin
        c.w1_rd = 1'b1;
        c.clr_k = 1'b1;
      end
      S_P_MUL: begin
        c.p_ld = 1'b1;
      end
      S_K_ISSUE: begin
        c.w2_iss = 1'b1;
        c.cond   = C_K_MORE;
        c.target = S_K_ISSUE;
      end
      S_J_ADV: begin
        c.j_adv  = 1'b1;
        c.cond   = C_J_MORE;
        c.target = S_W1_READ;
      end
      S_I_ADV: begin
        c.i_adv  = 1'b1;
        c.cond   = C_I_MORE;
        c.target = S_W1_READ;
      end
      S_SCAN_PREP: begin
        c.scan_clr = 1'b1;
      end
      S_SCAN: begin
        c.scan_cmp = 1'b1;
        c.cond     = C_K_MORE;
        c.target   = S_SCAN;
      end
      S_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/lnet_seq.sv =====
// ----------------------------------------------------------------------------
// lnet_seq
// Microcode sequencer: step counter, control table lookup and conditional
// jumps on the loop status of the datapath.
// ----------------------------------------------------------------------------
module lnet_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lnet_pkg::stat_t stat,
  output logic            busy,
  output lnet_pkg::ctrl_t ctrl
);
  import lnet_pkg::*;

  logic [3:0] pc;
  logic [3:0] pc_next;
  logic       take;

  assign ctrl = ucode(pc);
  assign busy = (pc != S_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NOT_EVAL: take = !stat.is_eval;
      C_K_MORE:   take = !stat.k_last;
      C_J_MORE:   take = !stat.j_last;
      C_I_MORE:   take = !stat.i_last;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (pc == S_IDLE) begin
      pc_next = start ? S_DISPATCH : S_IDLE;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== src/linear_two_layer_net_argmax_unit.sv =====
// ----------------------------------------------------------------------------
// linear_two_layer_net_argmax_unit
// Two-layer linear network with saturating accumulators and argmax report.
// ----------------------------------------------------------------------------
// Usage:
//   Present command, row_index, column_index and data_value with start high;
//   the transaction is taken on a clock edge where busy is low. Writes and
//   clear take effect on that edge. One result per transaction: decision and
//   has_decision are valid for the single cycle in which done is high, and
//   the receiver must take it then.
// One transaction at a time; start is taken again in the done cycle.
// The evaluation loop is set by the single shared multiplier path, which takes
// one output term per cycle plus three control steps per hidden unit and input
// and the I_ADV step of each input; the argmax reads one accumulator per cycle.
// Reset clears input values and accumulators; weights are undefined until
// written.
// ----------------------------------------------------------------------------
module linear_two_layer_net_argmax_unit #(
  parameter int NUM_INPUTS  = 4,
  parameter int NUM_HIDDEN  = 8,
  parameter int NUM_OUTPUTS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         command,
  input  logic [3:0]         row_index,
  input  logic [3:0]         column_index,
  input  logic signed [15:0] data_value,
  output logic               busy,
  output logic               done,
  output logic [3:0]         decision,
  output logic               has_decision
);
  import lnet_pkg::*;

  localparam int IW  = (NUM_INPUTS  > 1) ? $clog2(NUM_INPUTS)  : 1;
  localparam int JW  = (NUM_HIDDEN  > 1) ? $clog2(NUM_HIDDEN)  : 1;
  localparam int KW  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int A1N = NUM_INPUTS * NUM_HIDDEN;
  localparam int A2N = NUM_HIDDEN * NUM_OUTPUTS;
  localparam int A1W = (A1N > 1) ? $clog2(A1N) : 1;
  localparam int A2W = (A2N > 1) ? $clog2(A2N) : 1;
  localparam logic [4:0] NI5 = 5'(NUM_INPUTS);
  localparam logic [4:0] NH5 = 5'(NUM_HIDDEN);
  localparam logic [4:0] NO5 = 5'(NUM_OUTPUTS);
  localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  logic [2:0]     cmd_q;
  logic [IW-1:0]  i;
  logic [JW-1:0]  j;
  logic [KW-1:0]  k;
  logic [A1W-1:0] a1;
  logic [A2W-1:0] a2;

  logic signed [15:0] w1_mem [A1N];
  logic signed [15:0] w2_mem [A2N];
  logic signed [15:0] in_vals [NUM_INPUTS];
  logic signed [47:0] sums [NUM_OUTPUTS];

  logic signed [15:0] w1_q;
  logic signed [15:0] w2_q;
  logic signed [15:0] in_q;
  logic signed [31:0] p;
  logic signed [47:0] t;
  logic [KW-1:0]      rd_k1;
  logic               rd_v1;
  logic [KW-1:0]      t_k;
  logic               t_v;

  logic [KW-1:0]      rd_idx;
  logic signed [47:0] rd_sum;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_sat;

  logic signed [47:0] best;
  logic [KW-1:0]      best_idx;
  logic               found;

  logic               w1_we;
  logic               w2_we;
  logic               in_we;
  logic [A1W-1:0]     w1_waddr;
  logic [A2W-1:0]     w2_waddr;

  assign accept = start && !busy;

  assign stat.is_eval = (cmd_q == CMD_EVAL);
  assign stat.i_last  = (i == IW'(NUM_INPUTS - 1));
  assign stat.j_last  = (j == JW'(NUM_HIDDEN - 1));
  assign stat.k_last  = (k == KW'(NUM_OUTPUTS - 1));

  lnet_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // write decode
  assign w1_we = accept && (command == CMD_W1) &&
                 ({1'b0, row_index} < NI5) && ({1'b0, column_index} < NH5);
  assign w2_we = accept && (command == CMD_W2) &&
                 ({1'b0, row_index} < NH5) && ({1'b0, column_index} < NO5);
  assign in_we = accept && (command == CMD_INPUT) && ({1'b0, row_index} < NI5);
  assign w1_waddr = A1W'(int'(row_index) * NUM_HIDDEN + int'(column_index));
  assign w2_waddr = A2W'(int'(row_index) * NUM_OUTPUTS + int'(column_index));

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr_cnt) begin
      i  <= '0;
      j  <= '0;
      k  <= '0;
      a1 <= '0;
      a2 <= '0;
    end else begin
      if (ctrl.clr_k || ctrl.scan_clr) begin
        k <= '0;
      end
      if (ctrl.w2_iss || ctrl.scan_cmp) begin
        k <= k + 1'b1;
      end
      if (ctrl.w2_iss) begin
        a2 <= a2 + 1'b1;
      end
      if (ctrl.j_adv) begin
        j  <= j + 1'b1;
        a1 <= a1 + 1'b1;
      end
      if (ctrl.i_adv) begin
        i  <= i + 1'b1;
        j  <= '0;
        a2 <= '0;
      end
    end
  end

  // weight memories
  always_ff @(posedge clk) begin
    if (w1_we) begin
      w1_mem[w1_waddr] <= data_value;
    end
    if (ctrl.w1_rd) begin
      w1_q <= w1_mem[a1];
    end
  end

  always_ff @(posedge clk) begin
    if (w2_we) begin
      w2_mem[w2_waddr] <= data_value;
    end
    if (ctrl.w2_iss) begin
      w2_q <= w2_mem[a2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NUM_INPUTS; n++) begin
        in_vals[n] <= '0;
      end
    end else if (in_we) begin
      in_vals[row_index[IW-1:0]] <= data_value;
    end
  end

  // product pipeline: input*w1, then times w2, then saturating add
  always_ff @(posedge clk) begin
    if (ctrl.w1_rd) begin
      in_q <= in_vals[i];
    end
    if (ctrl.p_ld) begin
      p <= 32'(in_q) * 32'(w1_q);
    end
    if (rd_v1) begin
      t <= 48'(p) * 48'(w2_q);
    end
    rd_k1 <= k;
    t_k   <= rd_k1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v1 <= 1'b0;
      t_v   <= 1'b0;
    end else begin
      rd_v1 <= ctrl.w2_iss;
      t_v   <= rd_v1;
    end
  end

  // one accumulator read port, shared by the add stage and the scan
  assign rd_idx   = t_v ? t_k : k;
  assign rd_sum   = sums[rd_idx];
  assign sum_wide = {rd_sum[47], rd_sum} + {t[47], t};
  assign sum_sat  = (sum_wide[48] != sum_wide[47]) ?
                    (sum_wide[48] ? SUM_MIN : SUM_MAX) : sum_wide[47:0];

  always_ff @(posedge clk) begin
    if (rst || (accept && (command == CMD_CLEAR))) begin
      for (int n = 0; n < NUM_OUTPUTS; n++) begin
        sums[n] <= '0;
      end
    end else if (t_v) begin
      sums[t_k] <= sum_sat;
    end
  end

  // argmax scan: strictly greater wins, so the lowest index keeps a tie
  always_ff @(posedge clk) begin
    if (rst || ctrl.scan_clr) begin
      best     <= '0;
      best_idx <= '0;
      found    <= 1'b0;
    end else if (ctrl.scan_cmp && (rd_sum > best)) begin
      best     <= rd_sum;
      best_idx <= k;
      found    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
    end
  end

  assign decision     = 4'(best_idx);
  assign has_decision = found;

endmodule

// ===== src/lnet_checker.sv =====
// ----------------------------------------------------------------------------
// lnet_checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
module lnet_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [3:0] decision,
  input logic       has_decision
);

  // a result only appears once the block is free again
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // busy ends exactly when the result is shown
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // an accepted transaction makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");

  // done is a strobe: it is never high twice in a row
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // no winner reports index zero
  assert property (@(posedge clk) disable iff (rst)
    (done && !has_decision) |-> (decision == 4'd0))
    else $error("decision not zero without a winner");

endmodule

bind linear_two_layer_net_argmax_unit lnet_checker u_lnet_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .decision     (decision),
  .has_decision (has_decision)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_two_layer_net_argmax_unit: a queue-fed
// driver issues weight, input, evaluate, clear and spare commands with random
// idle gaps, and a monitor compares every decision with a local prediction
// of the saturating Q24.24 accumulators and their argmax.
// ----------------------------------------------------------------------------
module tb;
  import lnet_pkg::*;

  localparam int NI = 4;
  localparam int NH = 8;
  localparam int NO = 4;
  localparam int RANDOM_CMDS = 1800;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 6000000;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 64'sd1;

  typedef struct {
    logic [2:0]         cmd;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] val;
    int unsigned        gap;
  } net_cmd_t;

  typedef struct {
    logic [3:0] idx;
    logic       found;
  } argmax_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic [2:0]         command;
  logic [3:0]         row_index;
  logic [3:0]         column_index;
  logic signed [15:0] data_value;
  logic               busy;
  logic               done;
  logic [3:0]         decision;
  logic               has_decision;

  net_cmd_t cmd_queue[$];
  argmax_t  argmax_queue[$];

  logic signed [15:0] hid_weight [NI*NH];
  logic signed [15:0] out_weight [NH*NO];
  logic signed [15:0] in_value [NI];
  longint             out_sum [NO];

  int unsigned idle_left;
  int unsigned quiet_left;
  int          error_count;
  int          cycle_count;

  linear_two_layer_net_argmax_unit #(
    .NUM_INPUTS(NI),
    .NUM_HIDDEN(NH),
    .NUM_OUTPUTS(NO)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .row_index(row_index),
    .column_index(column_index),
    .data_value(data_value),
    .busy(busy),
    .done(done),
    .decision(decision),
    .has_decision(has_decision)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Apply one command to the local network copy and queue the argmax it yields.
  task run_network_command(input logic [2:0] cmd, input logic [3:0] row,
                           input logic [3:0] col, input logic signed [15:0] val);
    longint  prod;
    longint  acc;
    longint  best;
    argmax_t res;
    begin
      case (cmd)
        CMD_W1: begin
          if (row < NI && col < NH) hid_weight[row*NH + col] = val;
        end
        CMD_W2: begin
          if (row < NH && col < NO) out_weight[row*NO + col] = val;
        end
        CMD_INPUT: begin
          if (row < NI) in_value[row] = val;
        end
        CMD_EVAL: begin
          for (int i = 0; i < NI; i++) begin
            for (int j = 0; j < NH; j++) begin
              prod = longint'(in_value[i]) * longint'(hid_weight[i*NH + j]);
              for (int k = 0; k < NO; k++) begin
                acc = out_sum[k] + prod * longint'(out_weight[j*NO + k]);
                if (acc > SUM_HI) acc = SUM_HI;
                if (acc < SUM_LO) acc = SUM_LO;
                out_sum[k] = acc;
              end
            end
          end
        end
        CMD_CLEAR: begin
          for (int k = 0; k < NO; k++) out_sum[k] = 0;
        end
        default: begin
        end
      endcase
      best = 0;
      res.idx = '0;
      res.found = 1'b0;
      for (int k = 0; k < NO; k++) begin
        if (out_sum[k] > best) begin
          best = out_sum[k];
          res.idx = k[3:0];
          res.found = 1'b1;
        end
      end
      argmax_queue.insert(argmax_queue.size(), res);
    end
  endtask

  // Queue one command; the gap is the idle time before it goes out.
  task add_cmd(input logic [2:0] cmd, input logic [3:0] row, input logic [3:0] col,
               input logic signed [15:0] val);
    net_cmd_t    c;
    int unsigned r;
    begin
      c.cmd = cmd;
      c.row = row;
      c.col = col;
      c.val = val;
      if (quiet_left > 0) begin
        quiet_left--;
        c.gap = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          quiet_left = $urandom_range(20, 60);
          c.gap = 0;
        end else if (r < 45) begin
          c.gap = 0;
        end else if (r < 85) begin
          c.gap = $urandom_range(1, 4);
        end else if (r < 97) begin
          c.gap = $urandom_range(5, 24);
        end else begin
          c.gap = $urandom_range(25, 300);
        end
      end
      cmd_queue.insert(cmd_queue.size(), c);
    end
  endtask

  function automatic logic signed [15:0] rand_data();
    int unsigned r;
    logic [31:0] raw;
    r = $urandom_range(0, 99);
    raw = $urandom();
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        3: return 16'shFFFF;
        default: return 16'sh0001;
      endcase
    end
    if (r < 35) return 16'(int'($urandom_range(0, 1023)) - 512);
    return raw[15:0];
  endfunction

  function automatic logic [3:0] rand_index(input int limit);
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, limit - 1));
  endfunction

  // Driver: present the next command once the gap in front of it has passed.
  always @(posedge clk) begin : driver
    logic     launch;
    net_cmd_t nxt;
    launch = 1'b0;
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        run_network_command(command, row_index, column_index, data_value);
        if (cmd_queue.size() > 0 && cmd_queue[0].gap == 0) begin
          launch = 1'b1;
        end else begin
          start <= 1'b0;
          if (cmd_queue.size() > 0) idle_left <= cmd_queue[0].gap - 1;
        end
      end else if (!start && cmd_queue.size() > 0) begin
        if (idle_left > 0) idle_left <= idle_left - 1;
        else launch = 1'b1;
      end
      if (launch) begin
        nxt = cmd_queue.pop_front();
        start <= 1'b1;
        command <= nxt.cmd;
        row_index <= nxt.row;
        column_index <= nxt.col;
        data_value <= nxt.val;
      end
    end
  end

  // Monitor: every strobed result retires the oldest predicted argmax.
  always @(posedge clk) begin : monitor
    argmax_t want;
    if (!rst && done) begin
      if (argmax_queue.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = argmax_queue.pop_front();
        if (has_decision !== want.found)
          report_mismatch($sformatf("has_decision got %b expected %b",
                                    has_decision, want.found));
        if (decision !== want.idx)
          report_mismatch($sformatf("decision got %0d expected %0d",
                                    decision, want.idx));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("linear_two_layer_net_argmax_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [2:0]  c;
    int unsigned r;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_W1;
    row_index = '0;
    column_index = '0;
    data_value = '0;
    error_count = 0;
    cycle_count = 0;
    quiet_left = 0;
    idle_left = 0;
    for (int i = 0; i < NI*NH; i++) hid_weight[i] = '0;
    for (int i = 0; i < NH*NO; i++) out_weight[i] = '0;
    for (int i = 0; i < NI; i++) in_value[i] = '0;
    for (int k = 0; k < NO; k++) out_sum[k] = 0;

    // Fill every weight before any evaluation: first weights at the negative
    // extreme, outputs 0 and 1 identical so they tie, 2 opposite, 3 zero.
    for (int i = 0; i < NI; i++)
      for (int j = 0; j < NH; j++)
        add_cmd(CMD_W1, 4'(i), 4'(j), 16'sh8000);
    for (int j = 0; j < NH; j++) begin
      add_cmd(CMD_W2, 4'(j), 4'd0, 16'sh8000);
      add_cmd(CMD_W2, 4'(j), 4'd1, 16'sh8000);
      add_cmd(CMD_W2, 4'(j), 4'd2, 16'sh7FFF);
      add_cmd(CMD_W2, 4'(j), 4'd3, 16'sh0000);
    end

    // zero inputs, then both saturation limits, ties, clear and ignored writes
    add_cmd(CMD_EVAL, 4'd0, 4'd0, 16'sh0000);
    add_cmd(CMD_INPUT, 4'd0, 4'd15, 16'sh8000);
    add_cmd(CMD_EVAL, 4'd15, 4'd15, 16'shFFFF);
    add_cmd(CMD_INPUT, 4'd0, 4'd0, 16'sh7FFF);
    add_cmd(CMD_EVAL, 4'd0, 4'd0, 16'sh0000);
    add_cmd(CMD_EVAL, 4'd0, 4'd0, 16'sh0000);
    add_cmd(CMD_CLEAR, 4'd15, 4'd15, 16'sh7FFF);
    add_cmd(CMD_SPARE_FIRST, 4'd0, 4'd0, 16'sh0000);
    add_cmd(CMD_SPARE_FIRST + 3'd1, 4'd15, 4'd0, 16'sh8000);
    add_cmd(CMD_SPARE_LAST, 4'd15, 4'd15, 16'shFFFF);
    add_cmd(CMD_W1, 4'(NI), 4'd0, 16'sh7FFF);
    add_cmd(CMD_W1, 4'd0, 4'(NH), 16'sh7FFF);
    add_cmd(CMD_W2, 4'(NH), 4'd0, 16'sh7FFF);
    add_cmd(CMD_W2, 4'd0, 4'(NO), 16'sh7FFF);
    add_cmd(CMD_INPUT, 4'd15, 4'd0, 16'shFFFF);
    add_cmd(CMD_INPUT, 4'd1, 4'd0, 16'sh0001);
    add_cmd(CMD_INPUT, 4'd0, 4'd0, 16'sh0000);
    add_cmd(CMD_EVAL, 4'd0, 4'd0, 16'sh0000);
    add_cmd(CMD_W2, 4'(NH - 1), 4'(NO - 1), 16'sh7FFF);
    add_cmd(CMD_EVAL, 4'd0, 4'd0, 16'sh0000);
    add_cmd(CMD_CLEAR, 4'd0, 4'd0, 16'sh0000);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_cmd(CMD_W1, rand_index(NI), rand_index(NH), rand_data());
      end else if (r < 50) begin
        add_cmd(CMD_W2, rand_index(NH), rand_index(NO), rand_data());
      end else if (r < 68) begin
        add_cmd(CMD_INPUT, rand_index(NI), 4'($urandom_range(0, 15)), rand_data());
      end else begin
        if (r < 85) c = CMD_EVAL;
        else if (r < 91) c = CMD_CLEAR;
        else c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        add_cmd(c, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'($urandom()));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0 || start || argmax_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && argmax_queue.size() == 0) begin
      $display("linear_two_layer_net_argmax_unit verification clean");
    end else begin
      $display("linear_two_layer_net_argmax_unit verification failed");
    end
    $finish;
  end

endmodule
